// File: rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for the index selection sorter
// Controller states, controller-to-datapath command and status bundles,
// and the fixed field widths of the stream channels.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int HW_SLOTS  = 16;  // position field is 4 bits wide
    localparam int POS_W     = 4;
    localparam int VAL_W     = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - VAL_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    typedef struct packed {
        logic load;        // store the incoming transfer
        logic close;       // incoming transfer ends the set
        logic min_issue;   // open a scan at the start slot
        logic scan_take;   // consume the pending store read
        logic scan_issue;  // read the next slot of the scan
        logic swap_a;      // move start entry into the minimum slot
        logic swap_b;      // move minimum into the start slot, advance
        logic out_issue;   // read the store for the next result
        logic out_load;    // load the output register
    } cmd_t;

    typedef struct packed {
        logic sort_more;   // another start slot remains
        logic scan_more;   // scan index still below the count
        logic out_last;    // current result is the final one
        logic out_free;    // output register can take a result
    } sts_t;

endpackage

// File: rtl/index_selection_sorter.sv
// ----------------------------------------------------------------------------
// index_selection_sorter: indirect selection sort of signed 32-bit values
// Loads a set on the slave channel, sorts arrival positions by value and
// streams position/value pairs in ascending order on the master channel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one signed value per transfer, s_tlast closes the set. The
//   set holds min(DEPTH, 16) values; later values are dropped and flag the
//   run as overflowed on m_tuser.
//   Master side: one transfer per loaded value, ascending by value, m_tlast
//   on the final one. Equal values leave in selection-sort swap order.
//   Order of work for a set: the values load, then the sort makes one store
//   read per compare on the single read port of the value RAM and moves each
//   swap through ST_SWAP_A then ST_SWAP_B, then each result takes a store
//   read in ST_OUT_RD and a load of the output register in ST_OUT_WR.
//   s_tready is low from the closing transfer until the final result sits in
//   the output register; the next set may load while that result waits.
//   A stalled receiver holds the output register and the result sequencer.
//   Reset (aresetn low, synchronous) empties the set and the output register;
//   the block then accepts input at once.
// ----------------------------------------------------------------------------
module index_selection_sorter #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iss_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] sample_value
    input  logic                          s_tlast,   // ends_set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iss_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] source_position,
                                                     // [35:4] sorted_value
    output logic                          m_tlast,   // end_of_run
    output logic                          m_tuser    // overflowed
);

    iss_pkg::cmd_t cmd;
    iss_pkg::sts_t sts;

    iss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iss_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_value (s_tdata[iss_pkg::VAL_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/iss_ram.sv
// ----------------------------------------------------------------------------
// iss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl: sequencer of the index selection sorter
// Steps through load, selection scan, swap and result phases and issues
// one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module iss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  iss_pkg::sts_t sts,
    output iss_pkg::cmd_t cmd
);

    iss_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iss_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iss_pkg::ST_LOAD: begin
                if (s_tvalid && s_tlast) begin
                    state_next = iss_pkg::ST_START;
                end
            end
            iss_pkg::ST_START: begin
                state_next = sts.sort_more ? iss_pkg::ST_SCAN : iss_pkg::ST_OUT_RD;
            end
            iss_pkg::ST_SCAN: begin
                if (!sts.scan_more) begin
                    state_next = iss_pkg::ST_SWAP_A;
                end
            end
            iss_pkg::ST_SWAP_A: state_next = iss_pkg::ST_SWAP_B;
            iss_pkg::ST_SWAP_B: state_next = iss_pkg::ST_START;
            iss_pkg::ST_OUT_RD: state_next = iss_pkg::ST_OUT_WR;
            iss_pkg::ST_OUT_WR: begin
                if (sts.out_free) begin
                    state_next = sts.out_last ? iss_pkg::ST_LOAD : iss_pkg::ST_OUT_RD;
                end
            end
            default: state_next = iss_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            iss_pkg::ST_LOAD: begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid;
                cmd.close = s_tvalid && s_tlast;
            end
            iss_pkg::ST_START: cmd.min_issue = sts.sort_more;
            iss_pkg::ST_SCAN: begin
                cmd.scan_take  = 1'b1;
                cmd.scan_issue = sts.scan_more;
            end
            iss_pkg::ST_SWAP_A: cmd.swap_a    = 1'b1;
            iss_pkg::ST_SWAP_B: cmd.swap_b    = 1'b1;
            iss_pkg::ST_OUT_RD: cmd.out_issue = 1'b1;
            iss_pkg::ST_OUT_WR: cmd.out_load  = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// File: rtl/iss_datapath.sv
// ----------------------------------------------------------------------------
// iss_datapath: storage, scan registers and output register of the sorter
// Holds the value store, the position order list, the running minimum of
// the current scan and the result register on the master side.
// ----------------------------------------------------------------------------
module iss_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iss_pkg::cmd_t                 cmd,
    output iss_pkg::sts_t                 sts,
    input  logic [iss_pkg::VAL_W-1:0]     in_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iss_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    localparam int CAPACITY = (DEPTH < iss_pkg::HW_SLOTS) ? DEPTH : iss_pkg::HW_SLOTS;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic [AW-1:0]             start_reg, start_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             k_reg, k_next;
    logic [AW-1:0]             min_slot_reg, min_slot_next;
    logic [AW-1:0]             min_pos_reg, min_pos_next;
    logic [iss_pkg::VAL_W-1:0] min_val_reg, min_val_next;
    logic                      first_reg, first_next;
    logic [AW-1:0]             pend_slot_reg, pend_slot_next;
    logic [AW-1:0]             pend_pos_reg, pend_pos_next;
    logic                      out_valid_reg, out_valid_next;
    logic [iss_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic [iss_pkg::VAL_W-1:0] out_val_reg, out_val_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic [AW-1:0]             order_reg [CAPACITY];
    logic [AW-1:0]             ord_ra, ord_rd, ord_wa, ord_wd;
    logic                      ord_we;

    logic                      ram_we, ram_re;
    logic [iss_pkg::VAL_W-1:0] ram_rd;
    logic                      has_room, is_less;
    logic [CW-1:0]             start_inc, k_inc;

    assign has_room  = cnt_reg < CAP_C;
    assign start_inc = CW'(start_reg) + ONE_C;
    assign k_inc     = k_reg + ONE_C;
    assign is_less   = $signed(ram_rd) < $signed(min_val_reg);

    assign sts.sort_more = start_inc < cnt_reg;
    assign sts.scan_more = idx_reg < cnt_reg;
    assign sts.out_last  = k_inc == cnt_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // single read port of the order list, shared by scan, swap and output
    always_comb begin
        if (cmd.min_issue || cmd.swap_a) begin
            ord_ra = start_reg;
        end else if (cmd.scan_issue) begin
            ord_ra = idx_reg[AW-1:0];
        end else begin
            ord_ra = k_reg[AW-1:0];
        end
    end
    assign ord_rd = order_reg[ord_ra];

    always_comb begin
        ord_we = 1'b0;
        ord_wa = cnt_reg[AW-1:0];
        ord_wd = cnt_reg[AW-1:0];
        if (cmd.load && has_room) begin
            ord_we = 1'b1;
        end else if (cmd.swap_a) begin
            ord_we = 1'b1;
            ord_wa = min_slot_reg;
            ord_wd = ord_rd;
        end else if (cmd.swap_b) begin
            ord_we = 1'b1;
            ord_wa = start_reg;
            ord_wd = min_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_reg[ord_wa] <= ord_wd;
        end
    end

    assign ram_we = cmd.load && has_room;
    assign ram_re = cmd.min_issue || cmd.scan_issue || cmd.out_issue;

    iss_ram #(
        .WIDTH (iss_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (in_value),
        .rd_en   (ram_re),
        .rd_addr (ord_rd),
        .rd_data (ram_rd)
    );

    always_comb begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        min_slot_next  = min_slot_reg;
        min_pos_next   = min_pos_reg;
        min_val_next   = min_val_reg;
        first_next     = first_reg;
        pend_slot_next = pend_slot_reg;
        pend_pos_next  = pend_pos_reg;
        out_pos_next   = out_pos_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;

        if (cmd.load) begin
            if (has_room) begin
                cnt_next = cnt_reg + ONE_C;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.close) begin
            start_next = '0;
            k_next     = '0;
        end
        if (cmd.min_issue) begin
            min_slot_next = start_reg;
            min_pos_next  = ord_rd;
            first_next    = 1'b1;
            idx_next      = start_inc;
        end
        // the first read of a scan is the start slot itself
        if (cmd.scan_take) begin
            if (first_reg) begin
                min_val_next = ram_rd;
                first_next   = 1'b0;
            end else if (is_less) begin
                min_val_next  = ram_rd;
                min_slot_next = pend_slot_reg;
                min_pos_next  = pend_pos_reg;
            end
        end
        if (cmd.scan_issue) begin
            pend_slot_next = idx_reg[AW-1:0];
            pend_pos_next  = ord_rd;
            idx_next       = idx_reg + ONE_C;
        end
        if (cmd.swap_b) begin
            start_next = start_reg + AW'(1);
        end
        if (cmd.out_issue) begin
            pend_pos_next = ord_rd;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_pos_next   = iss_pkg::POS_W'(pend_pos_reg);
            out_val_next   = ram_rd;
            out_last_next  = sts.out_last;
            out_ovf_next   = ovf_reg;
            k_next         = k_inc;
            if (sts.out_last) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg     <= start_next;
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        min_slot_reg  <= min_slot_next;
        min_pos_reg   <= min_pos_next;
        min_val_reg   <= min_val_next;
        pend_slot_reg <= pend_slot_next;
        pend_pos_reg  <= pend_pos_next;
        out_pos_reg   <= out_pos_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{iss_pkg::M_PAD_W{1'b0}}, out_val_reg, out_pos_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

// File: rtl/iss_checker.sv
// ----------------------------------------------------------------------------
// iss_checker: port-level checks for the index selection sorter
// Watches the stream channels and flags handshake and sequencing faults.
// ----------------------------------------------------------------------------
module iss_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [iss_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear output or open input");

    // no loading while a run is still being emitted
    a_no_load_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open while a run is mid-transfer");

    // a closing transfer stops the input for the sort
    a_close_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input stayed open after the closing transfer");

endmodule

bind index_selection_sorter iss_checker u_iss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
